/* rtl/sfc_pkg.sv */
`default_nettype none

package sfc_pkg;

   localparam int FrameDataBytes = 8;
   localparam int IndexWidth     = 4;
   localparam int ReqDataWidth   = 24;
   localparam int RspDataWidth   = 48;

   localparam logic [7:0]  CrcPolyReflected = 8'h8C;
   localparam logic [7:0]  ConfigUnset      = 8'hFF;
   localparam logic [15:0] TempFail         = 16'h7FFF;
   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(FrameDataBytes);

   typedef logic [7:0] byte_type;

   function automatic byte_type crc8_update(input byte_type crc, input byte_type b);
      byte_type c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPolyReflected;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // times 5, wrapped to 16 bits
   function automatic logic signed [15:0] times5(input logic signed [15:0] v);
      return (v <<< 2) + v;
   endfunction

   // halve, truncating toward zero
   function automatic logic signed [15:0] halve(input logic signed [15:0] v);
      logic signed [15:0] s;
      s = v + {15'b0, v[15]};
      return s >>> 1;
   endfunction

endpackage

`default_nettype wire

/* rtl/scratchpad_frame_checker.sv */
`default_nettype none

// Checks the nine-byte scratchpad of a one-wire temperature sensor. Send the
// bytes in bus order, one request each; the ninth (the CRC) closes the frame
// and yields one response: temperature in hundredths of a degree (32767 on a
// CRC mismatch), crc_ok, and, when the configuration byte must be rewritten,
// the alarm bytes and new configuration byte to write back (zero otherwise).
// One request is accepted every cycle but for a closing byte held by a waiting
// response; it passes the request register, then the response register. Bytes
// that produce no response pass even while a response waits.
module scratchpad_frame_checker
   import sfc_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // [7:0] data_byte, [8] has_address, [16:9] expected_config, [23:17] zero
   input  wire  [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // [15:0] temperature_centi, [16] crc_ok, [17] rewrite_needed,
   // [25:18] alarm_high_byte, [33:26] alarm_low_byte, [41:34] new_config_byte,
   // [47:42] zero
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic                    req_valid_ff;
   logic [7:0]              data_byte_ff;
   logic                    has_address_ff;
   logic [7:0]              expected_config_ff;

   logic [IndexWidth-1:0]   byte_index_ff, byte_index_in;
   byte_type                running_crc_ff, running_crc_in;
   byte_type                frame_bytes_ff [FrameDataBytes];

   logic                    rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic                    is_last;
   logic                    out_free;
   logic                    stage_go;

   logic signed [15:0]      raw_temp;
   logic signed [15:0]      temp_a;
   logic signed [15:0]      temp_b;
   logic signed [15:0]      temp_c;
   logic signed [15:0]      temp_d;
   logic                    crc_ok;
   logic                    rewrite;
   logic [15:0]             temp_out;
   byte_type                alarm_high;
   byte_type                alarm_low;
   byte_type                new_config;

   assign is_last    = (byte_index_ff == LastIndex);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_go   = req_valid_ff && (!is_last || out_free);
   assign req_tready = !req_valid_ff || stage_go;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign raw_temp = {frame_bytes_ff[1], frame_bytes_ff[0]};
   assign temp_a   = times5(raw_temp);
   assign temp_b   = halve(temp_a);
   assign temp_c   = times5(temp_b);
   assign temp_d   = halve(temp_c);

   assign crc_ok  = (running_crc_ff == data_byte_ff);
   assign rewrite = crc_ok && has_address_ff
                    && (frame_bytes_ff[4] != ConfigUnset)
                    && (frame_bytes_ff[4] != expected_config_ff);

   assign temp_out   = crc_ok ? 16'(temp_d) : TempFail;
   assign alarm_high = rewrite ? frame_bytes_ff[2] : 8'h00;
   assign alarm_low  = rewrite ? frame_bytes_ff[3] : 8'h00;
   assign new_config = rewrite ? expected_config_ff : 8'h00;

   always_comb begin
      rsp_data_in = {6'b0, new_config, alarm_low, alarm_high, rewrite, crc_ok, temp_out};
      if (is_last) begin
         byte_index_in  = '0;
         running_crc_in = '0;
      end else begin
         byte_index_in  = byte_index_ff + IndexWidth'(1);
         running_crc_in = crc8_update(running_crc_ff, data_byte_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_index_ff <= '0;
         running_crc_ff <= '0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (stage_go) begin
            byte_index_ff  <= byte_index_in;
            running_crc_ff <= running_crc_in;
         end
         if (stage_go && is_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         data_byte_ff       <= req_tdata[7:0];
         has_address_ff     <= req_tdata[8];
         expected_config_ff <= req_tdata[16:9];
      end
      if (stage_go && !is_last) begin
         frame_bytes_ff[byte_index_ff[2:0]] <= data_byte_ff;
      end
      if (stage_go && is_last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb
   import sfc_pkg::*;
();

   localparam int CycleLimit = 200000;

   typedef struct packed {
      logic [7:0]         new_config;
      logic [7:0]         alarm_low;
      logic [7:0]         alarm_high;
      logic               rewrite;
      logic               crc_ok;
      logic signed [15:0] centi;
   } reading_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // [7:0] data_byte, [8] has_address, [16:9] expected_config, [23:17] zero
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [15:0] temperature_centi, [16] crc_ok, [17] rewrite_needed,
   // [25:18] alarm_high_byte, [33:26] alarm_low_byte, [41:34] new_config_byte
   logic [RspDataWidth-1:0] rsp_tdata;

   reading_type pending_readings[$];
   logic [3:0] frame_pos     = '0;
   logic [7:0] crc_acc       = '0;
   logic [7:0] scratch_bytes[FrameDataBytes];
   bit         idle_on       = 1'b0;
   int         mismatch_count = 0;
   int         bytes_sent    = 0;
   int         frames_good   = 0;
   int         frames_bad    = 0;
   int         rewrites      = 0;

   scratchpad_frame_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("watchdog expired with %0d readings outstanding", pending_readings.size());
      $display("Verification failed");
      $finish;
   end

   function automatic logic [7:0] crc8_reflected(input logic [7:0] crc,
                                                 input logic [7:0] data_byte);
      logic [7:0] c;
      c = crc ^ data_byte;
      repeat (8) c = c[0] ? ((c >> 1) ^ CrcPolyReflected) : (c >> 1);
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      if (mismatch_count <= 30) begin
         $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
      end
   endtask

   task automatic track_scratchpad_byte(input logic [7:0] data_byte, input logic has_address,
                                        input logic [7:0] expected_config);
      reading_type        r;
      logic signed [15:0] t;
      if (frame_pos < 4'(FrameDataBytes)) begin
         scratch_bytes[frame_pos[2:0]] = data_byte;
         crc_acc = crc8_reflected(crc_acc, data_byte);
         frame_pos++;
      end else begin
         r = '0;
         if (crc_acc != data_byte) begin
            r.centi = TempFail;
            frames_bad++;
         end else begin
            t = {scratch_bytes[1], scratch_bytes[0]};
            t = t * 16'sd5;
            t = t / 16'sd2;
            t = t * 16'sd5;
            t = t / 16'sd2;
            r.centi   = t;
            r.crc_ok  = 1'b1;
            r.rewrite = has_address && scratch_bytes[4] != ConfigUnset
                        && scratch_bytes[4] != expected_config;
            if (r.rewrite) begin
               r.alarm_high = scratch_bytes[2];
               r.alarm_low  = scratch_bytes[3];
               r.new_config = expected_config;
               rewrites++;
            end
            frames_good++;
         end
         frame_pos = '0;
         crc_acc   = '0;
         pending_readings.push_back(r);
      end
   endtask

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("response with no frame closed", rsp_tdata[15:0], '0);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[15:0] !== want.centi)
               report_mismatch("temperature_centi", rsp_tdata[15:0], want.centi);
            if (rsp_tdata[16] !== want.crc_ok)
               report_mismatch("crc_ok", 16'(rsp_tdata[16]), 16'(want.crc_ok));
            if (rsp_tdata[17] !== want.rewrite)
               report_mismatch("rewrite_needed", 16'(rsp_tdata[17]), 16'(want.rewrite));
            if (rsp_tdata[25:18] !== want.alarm_high)
               report_mismatch("alarm_high_byte", 16'(rsp_tdata[25:18]), 16'(want.alarm_high));
            if (rsp_tdata[33:26] !== want.alarm_low)
               report_mismatch("alarm_low_byte", 16'(rsp_tdata[33:26]), 16'(want.alarm_low));
            if (rsp_tdata[41:34] !== want.new_config)
               report_mismatch("new_config_byte", 16'(rsp_tdata[41:34]), 16'(want.new_config));
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] data_byte, input logic has_address,
                            input logic [7:0] expected_config);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataWidth'({expected_config, has_address, data_byte});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_scratchpad_byte(data_byte, has_address, expected_config);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [15:0] raw, input logic [7:0] alarm_high,
                             input logic [7:0] alarm_low, input logic [7:0] config_byte,
                             input logic has_address, input logic [7:0] expected_config,
                             input bit corrupt);
      logic [7:0] frame[9];
      logic [7:0] crc;
      frame[0] = raw[7:0];
      frame[1] = raw[15:8];
      frame[2] = alarm_high;
      frame[3] = alarm_low;
      frame[4] = config_byte;
      for (int i = 5; i < 8; i++) frame[i] = 8'($urandom);
      crc = '0;
      for (int i = 0; i < 8; i++) crc = crc8_reflected(crc, frame[i]);
      frame[8] = corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc;
      // side inputs are don't-care until the CRC byte
      for (int i = 0; i < 8; i++) begin
         send_byte(frame[i], 1'($urandom), 8'($urandom));
      end
      send_byte(frame[8], has_address, expected_config);
   endtask

   task automatic random_frame(input bit corrupt);
      logic [15:0] raw;
      logic [7:0]  expected_config;
      logic [7:0]  config_byte;
      case ($urandom_range(0, 3))
         0: raw = 16'($urandom);
         1: begin
            case ($urandom_range(0, 5))
               0: raw = 16'h0000;
               1: raw = 16'h7FFF;
               2: raw = 16'h8000;
               3: raw = 16'hFFFF;
               4: raw = 16'h0001;
               default: raw = 16'h8001;
            endcase
         end
         2: raw = 16'(int'($urandom_range(0, 2880)) - 880);
         default: begin
            raw[7:0]  = 8'($urandom);
            raw[15:8] = {8{raw[7]}};
         end
      endcase
      case ($urandom_range(0, 3))
         0: expected_config = ConfigUnset;
         1: expected_config = {1'b0, 2'($urandom), 5'h1F};
         default: expected_config = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: config_byte = ConfigUnset;
         1: config_byte = expected_config;
         2: config_byte = expected_config ^ (8'h01 << $urandom_range(0, 7));
         default: config_byte = 8'($urandom);
      endcase
      send_frame(raw, 8'($urandom), 8'($urandom), config_byte, 1'($urandom),
                 expected_config, corrupt);
   endtask

   task automatic test_directed_frames();
      idle_on = 1'b1;
      send_frame(16'h8000, 8'hFF, 8'h00, 8'h3F, 1'b1, 8'h7F, 1'b0);
      send_frame(16'h7FFF, 8'h00, 8'hFF, ConfigUnset, 1'b1, 8'h00, 1'b0);
      send_frame(16'hFFFF, 8'hA5, 8'h5A, 8'h5F, 1'b0, 8'hFF, 1'b1);
   endtask

   task automatic test_good_frames();
      repeat (100) begin
         idle_on = ($urandom_range(0, 4) != 0);
         random_frame(1'b0);
      end
   endtask

   task automatic test_corrupt_frames();
      repeat (40) begin
         idle_on = ($urandom_range(0, 4) != 0);
         random_frame(1'($urandom));
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (40) random_frame($urandom_range(0, 7) == 0);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_good_frames();
      test_corrupt_frames();
      test_back_to_back();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("Sent %0d scratchpad bytes: %0d frames with good CRC, %0d with bad CRC,",
               bytes_sent, frames_good, frames_bad);
      $display("%0d config rewrites flagged, %0d mismatches.", rewrites, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/sfc_pkg.sv
rtl/scratchpad_frame_checker.sv
tb/tb.sv
